[rtl/swm_pkg.sv]
// swm_pkg: shared widths, types and controller/datapath command and status structs
// for the sliding window median filter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int MED_BITS    = SAMPLE_BITS + 1;
  localparam int ADDR_BITS   = $clog2(WINDOW_MAX);
  localparam int CNT_BITS    = ADDR_BITS + 1;
  localparam int CFG_BITS    = 7;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [MED_BITS-1:0]    med_t;
  typedef logic [ADDR_BITS-1:0]          addr_t;
  typedef logic [CNT_BITS-1:0]           cnt_t;
  typedef logic [CFG_BITS-1:0]           cfg_t;

  typedef struct packed {
    logic accept;    // take the input item, update ring and counters
    logic sweep;     // merge pass over the sorted store
    logic finish;    // last write of the merge, swap banks
    logic med_rd_a;  // read upper middle entry
    logic med_rd_b;  // read lower middle entry, capture upper
    logic cap_b;     // capture lower middle entry
    logic load_out;  // load the result register
  } swm_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic has_result;
    logic out_busy;
  } swm_status_t;

endpackage

`default_nettype wire

[rtl/swm_if.sv]
// swm_in_if / swm_out_if: valid-ready channels for samples and medians.
// Depends on swm_pkg for payload types.
`timescale 1ns / 1ps
`default_nettype none

interface swm_in_if;
  import swm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swm_out_if;
  import swm_pkg::*;
  logic valid;
  logic ready;
  med_t median_x2;

  modport source (output valid, output median_x2, input ready);
  modport sink   (input valid, input median_x2, output ready);
endinterface

`default_nettype wire

[rtl/sliding_window_median_top.sv]
// sliding_window_median_top: top level of the running median filter.
// Depends on swm_pkg, swm_if, swm_ctrl and swm_datapath.
//
// usage
// - samples channel (sink): one item carries a signed sample and a restart
//   flag; restart drops all held samples before this one is taken
// - medians channel (source): one item per sample once the window is full,
//   twice the window median (sum of the two middle values for an even window)
// - cfg_wr_en / cfg_wr_data: window_size, written only while idle (unchecked by
//   the block); a write drops all held samples. zero acts as 1, above 64 as 64
// timing
// - one item at a time; a sample takes longer the more samples are held before
//   it, and longer when it gives a result, as only then are the two middle
//   entries read out and the result register loaded
// - the cost per held sample comes from the merge pass, which streams the sorted
//   store through its single registered read port into the other bank
// - a result is loaded after the bank swap and the readout of the two middles
// reset and stall
// - synchronous active-high reset empties the window, window_size is 3
// - the result register holds a median while the receiver stalls; the next
//   sample is still accepted and merged, and waits only to load its result
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median_top (
  input  wire logic           clk,
  input  wire logic           rst,
  swm_in_if.sink              samples,
  swm_out_if.source           medians,
  input  wire logic           cfg_wr_en,
  input  wire swm_pkg::cfg_t  cfg_wr_data
);
  import swm_pkg::*;

  swm_cmd_t    cmd;
  swm_status_t status;
  logic        out_valid;
  med_t        out_median;

  // sequencer: accept, merge sweep, bank swap, median readout
  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // stores, counters and the result register
  swm_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .sample      (samples.sample),
    .restart     (samples.restart),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (medians.ready),
    .out_valid   (out_valid),
    .out_median  (out_median)
  );

  // result register drives the output channel directly
  assign medians.valid     = out_valid;
  assign medians.median_x2 = out_median;

endmodule

`default_nettype wire

[rtl/swm_ctrl.sv]
// swm_ctrl: sequencing state machine for one item at a time.
// Depends on swm_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module swm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire swm_pkg::swm_status_t status,
  output swm_pkg::swm_cmd_t         cmd
);
  import swm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH,
    ST_MED_A,
    ST_MED_B,
    ST_MED_C,
    ST_OUT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (status.sweep_done) state <= ST_FINISH;
        end
        ST_FINISH: begin
          state <= status.has_result ? ST_MED_A : ST_IDLE;
        end
        ST_MED_A: state <= ST_MED_B;
        ST_MED_B: state <= ST_MED_C;
        ST_MED_C: state <= ST_OUT;
        ST_OUT: begin
          if (!status.out_busy) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    in_ready     = (state == ST_IDLE);
    cmd.accept   = (state == ST_IDLE) && in_valid;
    cmd.sweep    = (state == ST_SWEEP);
    cmd.finish   = (state == ST_FINISH);
    cmd.med_rd_a = (state == ST_MED_A);
    cmd.med_rd_b = (state == ST_MED_B);
    cmd.cap_b    = (state == ST_MED_C);
    cmd.load_out = (state == ST_OUT) && !status.out_busy;
  end

endmodule

`default_nettype wire

[rtl/swm_datapath.sv]
// swm_datapath: arrival ring, ping-pong sorted store, merge logic,
// median readout and result register. Depends on swm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swm_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire swm_pkg::swm_cmd_t    cmd,
  output swm_pkg::swm_status_t      status,
  input  wire swm_pkg::sample_t     sample,
  input  wire logic                 restart,
  input  wire logic                 cfg_wr_en,
  input  wire swm_pkg::cfg_t        cfg_wr_data,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output swm_pkg::med_t             out_median
);
  import swm_pkg::*;

  // stores
  sample_t ring  [WINDOW_MAX];
  sample_t bank0 [WINDOW_MAX];
  sample_t bank1 [WINDOW_MAX];

  // control state
  cfg_t  window_size;
  cnt_t  fill_count;
  addr_t oldest_pointer;
  logic  bank;          // bank holding the current sorted window
  logic  has_result;
  logic  drop_pending;
  logic  ins_pending;
  logic  carry_mode;
  logic  rd_valid;
  cnt_t  rd_ptr;
  addr_t wr_ptr;
  cnt_t  n_old;

  // payload
  sample_t sample_r;
  sample_t ring_q;
  sample_t bank0_q;
  sample_t bank1_q;
  sample_t sorted_q;
  sample_t carry;
  sample_t med_a;
  sample_t med_b;

  cnt_t  eff_len;
  cnt_t  half;
  addr_t addr_a;
  addr_t addr_b;
  cnt_t  f_start;
  addr_t op_start;
  logic  full;
  addr_t ring_addr;
  cnt_t  fill_inc;
  cnt_t  op_inc;
  addr_t rd_addr;
  logic  issue;
  logic  wr_en;
  addr_t wr_addr;
  sample_t wr_data;

  // clamp the configured length to 1..WINDOW_MAX
  always_comb begin
    if (window_size == '0) begin
      eff_len = cnt_t'(1);
    end else if (int'(window_size) > WINDOW_MAX) begin
      eff_len = cnt_t'(WINDOW_MAX);
    end else begin
      eff_len = cnt_t'(window_size);
    end
    half   = eff_len >> 1;
    addr_a = half[ADDR_BITS-1:0];
    addr_b = eff_len[0] ? half[ADDR_BITS-1:0] : addr_t'(half - cnt_t'(1));
  end

  // counter view at accept time, after restart and sanity clears
  always_comb begin
    f_start  = restart ? '0 : fill_count;
    op_start = restart ? '0 : oldest_pointer;
    if (f_start > eff_len) begin
      f_start  = '0;
      op_start = '0;
    end
    if (cnt_t'(op_start) >= eff_len) op_start = '0;
    full      = (f_start == eff_len);
    ring_addr = full ? op_start : f_start[ADDR_BITS-1:0];
    fill_inc  = f_start + cnt_t'(1);
    op_inc    = cnt_t'(op_start) + cnt_t'(1);
  end

  // word read back from the bank that holds the current window
  always_comb begin
    sorted_q = bank ? bank1_q : bank0_q;
  end

  // merge step on the word read back from the old bank; read address select
  always_comb begin
    issue   = cmd.sweep && (rd_ptr < n_old);
    wr_en   = 1'b0;
    wr_addr = wr_ptr;
    wr_data = sorted_q;
    if (cmd.sweep && rd_valid) begin
      if (drop_pending && (sorted_q == ring_q)) begin
        wr_en = 1'b0;
      end else if (carry_mode) begin
        wr_en   = 1'b1;
        wr_data = carry;
      end else if (ins_pending && (sample_r < sorted_q)) begin
        wr_en   = 1'b1;
        wr_data = sample_r;
      end else begin
        wr_en   = 1'b1;
        wr_data = sorted_q;
      end
    end else if (cmd.finish) begin
      wr_en   = 1'b1;
      wr_data = carry_mode ? carry : sample_r;
    end
    if (cmd.med_rd_a) begin
      rd_addr = addr_a;
    end else if (cmd.med_rd_b) begin
      rd_addr = addr_b;
    end else begin
      rd_addr = rd_ptr[ADDR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring[ring_addr] <= sample;
      ring_q          <= ring[ring_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && bank) bank0[wr_addr] <= wr_data;
    bank0_q <= bank0[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en && !bank) bank1[wr_addr] <= wr_data;
    bank1_q <= bank1[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size    <= cfg_t'(3);
      fill_count     <= '0;
      oldest_pointer <= '0;
      bank           <= 1'b0;
      has_result     <= 1'b0;
      drop_pending   <= 1'b0;
      ins_pending    <= 1'b0;
      carry_mode     <= 1'b0;
      rd_valid       <= 1'b0;
      rd_ptr         <= '0;
      wr_ptr         <= '0;
      n_old          <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_size    <= cfg_wr_data;
        fill_count     <= '0;
        oldest_pointer <= '0;
      end
      if (cmd.accept) begin
        sample_r     <= sample;
        drop_pending <= full;
        ins_pending  <= 1'b1;
        carry_mode   <= 1'b0;
        rd_valid     <= 1'b0;
        rd_ptr       <= '0;
        wr_ptr       <= '0;
        n_old        <= full ? eff_len : f_start;
        if (full) begin
          fill_count     <= eff_len;
          oldest_pointer <= (op_inc >= eff_len) ? '0 : op_inc[ADDR_BITS-1:0];
          has_result     <= 1'b1;
        end else begin
          fill_count     <= fill_inc;
          oldest_pointer <= (fill_inc == eff_len) ? '0 : op_start;
          has_result     <= (fill_inc == eff_len);
        end
      end
      if (cmd.sweep) begin
        rd_valid <= issue;
        if (issue) rd_ptr <= rd_ptr + cnt_t'(1);
        if (rd_valid) begin
          if (drop_pending && (sorted_q == ring_q)) begin
            drop_pending <= 1'b0;
          end else if (carry_mode) begin
            carry <= sorted_q;
          end else if (ins_pending && (sample_r < sorted_q)) begin
            carry       <= sorted_q;
            carry_mode  <= 1'b1;
            ins_pending <= 1'b0;
          end
        end
      end
      if (wr_en) wr_ptr <= wr_ptr + addr_t'(1);
      if (cmd.finish) bank <= ~bank;
      if (cmd.med_rd_b) med_a <= sorted_q;
      if (cmd.cap_b) med_b <= sorted_q;
      if (cmd.load_out) begin
        out_valid  <= 1'b1;
        out_median <= med_t'(med_a) + med_t'(med_b);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.sweep_done = (rd_ptr == n_old) && !rd_valid;
    status.has_result = has_result;
    status.out_busy   = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

[sim/swm_median_checker.sv]
// swm_median_checker: watches the sample, median and window channels of the
// running median filter, predicts each doubled median and compares it
// depends on swm_pkg and the swm_in_if / swm_out_if interfaces
`timescale 1ns / 1ps

module swm_median_checker (
  input wire logic           clk,
  input wire logic           rst,
  swm_in_if                  samples,
  swm_out_if                 medians,
  input wire logic           cfg_wr_en,
  input wire swm_pkg::cfg_t  cfg_wr_data,
  output int                 fail_count,
  output int                 outstanding
);
  import swm_pkg::*;

  localparam int WINDOW_RESET = 3;

  sample_t     held_q[$];    // window contents, oldest first
  med_t        median_q[$];  // doubled medians still to come
  int unsigned span;         // effective window length

  function automatic int unsigned span_of(input cfg_t v);
    if (v == 0) return 1;
    if (v > WINDOW_MAX) return WINDOW_MAX;
    return 32'(v);
  endfunction

  function automatic med_t doubled_median();
    sample_t ord [WINDOW_MAX];
    sample_t key;
    int      n, i, j;
    int      lower, upper;
    n = held_q.size();
    for (i = 0; i < n; i++) begin
      key = held_q[i];
      j = i;
      while (j > 0 && ord[j-1] > key) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = key;
    end
    if (n % 2 == 1) begin
      lower = int'(ord[n/2]);
      upper = lower;
    end else begin
      lower = int'(ord[n/2-1]);
      upper = int'(ord[n/2]);
    end
    return med_t'(lower + upper);
  endfunction

  task automatic note_mismatch(input string what);
    $display("checker: %s at %0t ns", what, $realtime);
    fail_count++;
  endtask

  task automatic take_sample(input sample_t s, input logic restart);
    if (restart) held_q.delete();
    held_q = {held_q, s};
    if (held_q.size() > span) void'(held_q.pop_front());
    if (held_q.size() == span) median_q = {median_q, doubled_median()};
  endtask

  initial begin
    fail_count  = 0;
    outstanding = 0;
    span        = WINDOW_RESET;
  end

  // sampled mid-cycle, where everything driven at the rising edge has settled
  always @(negedge clk) begin
    med_t want;
    if (rst) begin
      held_q.delete();
      median_q.delete();
      span = WINDOW_RESET;
    end else begin
      if (medians.valid && medians.ready) begin
        if (median_q.size() == 0) begin
          note_mismatch($sformatf("median_x2 %0d with none expected",
                                  medians.median_x2));
        end else begin
          want = median_q.pop_front();
          if (medians.median_x2 !== want)
            note_mismatch($sformatf("median_x2 got %0d expected %0d",
                                    medians.median_x2, want));
        end
      end
      if (cfg_wr_en) begin
        span = span_of(cfg_wr_data);
        held_q.delete();
      end
      if (samples.valid && samples.ready)
        take_sample(samples.sample, samples.restart);
    end
    outstanding = median_q.size();
  end

endmodule

[sim/testbench.sv]
// testbench: drives samples and window sizes into the running median filter
// with bursty input and a stalling receiver, and gives the verdict
// depends on swm_pkg, swm_if, sliding_window_median_top and swm_median_checker
`timescale 1ns / 1ps

module testbench;
  import swm_pkg::*;

  localparam int      ITEM_TARGET   = 1250;            // random items to send
  localparam int      SETTLE_CYCLES = WINDOW_MAX + 16; // room for the slowest sample
  localparam int      LONG_HOLD     = 500;             // receiver hold-off, cycles
  localparam int      TIME_LIMIT_NS = 10_000_000;
  localparam int      SWEEP_LEN     = 15;
  localparam int      LEAD_LEN      = 17;
  localparam sample_t SAMPLE_MIN    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam sample_t SAMPLE_MAX    = ~SAMPLE_MIN;

  // receiver behavior, switched at random intervals
  typedef enum int {RX_OPEN, RX_HALF, RX_SLOW} rx_mode_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  cfg_t cfg_wr_data;
  logic hold_req;      // asks the receiver for its one long hold-off
  int   fail_count;
  int   outstanding;
  int   burst_left;    // items left in the current input burst
  int   random_sent;

  swm_in_if  samples_if ();
  swm_out_if medians_if ();

  sliding_window_median_top uut (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples_if),
    .medians     (medians_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  swm_median_checker median_check (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples_if),
    .medians     (medians_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #TIME_LIMIT_NS;
    $display("timeout with %0d medians outstanding", outstanding);
    $display("testbench: FAIL");
    $finish;
  end

  // receiver: random stall pattern plus one long hold-off on request
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    bit       hold_done;
    medians_if.ready <= 1'b0;
    mode      = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        // block fills up behind the held result and stops taking samples
        hold_left--;
        medians_if.ready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN: medians_if.ready <= 1'b1;
          RX_HALF: medians_if.ready <= 1'($urandom_range(0, 1));
          default: medians_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // valid low with junk payload, which the block must ignore
  task automatic idle_cycles(input int n);
    repeat (n) begin
      samples_if.valid   <= 1'b0;
      samples_if.sample  <= sample_t'($urandom);
      samples_if.restart <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
  endtask

  // hold the item until a handshake; ready is looked at mid-cycle
  task automatic push_item(input sample_t s, input logic r);
    bit taken;
    samples_if.valid   <= 1'b1;
    samples_if.sample  <= s;
    samples_if.restart <= r;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = samples_if.ready;
      @(posedge clk);
    end
  endtask

  // bursts of random length, random gaps in between, some long bursts
  task automatic offer(input sample_t s, input logic r);
    if (burst_left == 0) begin
      idle_cycles($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
    burst_left--;
    push_item(s, r);
  endtask

  // all medians back, then room for a sample that gives none to finish
  task automatic settle();
    samples_if.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input cfg_t v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // extremes, a narrow band for duplicates, and full-range values
  function automatic sample_t pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return SAMPLE_MIN;
          1:       return SAMPLE_MAX;
          2:       return sample_t'(0);
          default: return sample_t'(-1);
        endcase
      end
      1, 2, 3: begin
        v = $urandom_range(0, 8);
        return sample_t'(v - 4);
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    cfg_t    sweep  [SWEEP_LEN];
    sample_t lead_s [LEAD_LEN];
    bit      lead_r [LEAD_LEN];
    cfg_t    v;
    int      phase;
    int      span;
    int      count;
    int      restart_odds;

    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    samples_if.valid   <= 1'b0;
    samples_if.sample  <= '0;
    samples_if.restart <= 1'b0;
    hold_req           <= 1'b0;
    burst_left  = 0;
    random_sent = 0;

    // window sizes in order: one, zero acting as one, even, the largest,
    // above the largest twice, then a spread of small and odd sizes
    sweep = '{7'd1, 7'd0, 7'd2, 7'd64, 7'd127, 7'd65, 7'd4, 7'd5,
              7'd3, 7'd6, 7'd8, 7'd9, 7'd15, 7'd31, 7'd33};

    // directed run at the reset window of three: extremes, duplicates,
    // restart on a full window and restart while still filling
    lead_s = '{SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
               0, 0, 0, -1, 1, 5, -5, 5, 3, -3, 21845, -21846};
    lead_r = '{0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (lead_s[i]) offer(lead_s[i], lead_r[i]);

    // even window: sum of the two middles at both ends of the range
    write_window(7'd2);
    offer(SAMPLE_MAX, 1'b0);
    offer(SAMPLE_MAX, 1'b0);
    offer(SAMPLE_MIN, 1'b0);
    offer(SAMPLE_MIN, 1'b0);

    // random phases, each under its own window size
    phase = 0;
    while (random_sent < ITEM_TARGET) begin
      if (phase < SWEEP_LEN)
        v = sweep[phase];
      else if ($urandom_range(0, 5) == 0)
        v = cfg_t'($urandom_range(13, 127));
      else
        v = cfg_t'($urandom_range(1, 12));
      write_window(v);
      span = (v == 0) ? 1 : ((v > WINDOW_MAX) ? WINDOW_MAX : int'(v));
      // the long hold-off lands in the window-of-five phase
      if (phase < SWEEP_LEN && v == 7'd5) hold_req <= 1'b1;
      count = span + ((span > 16) ? $urandom_range(20, 40) : $urandom_range(30, 90));
      // mostly long sequences that fill the window, sometimes restart noise
      restart_odds = (span <= 16 && $urandom_range(0, 3) == 0) ? 6 : 60;
      repeat (count) begin
        offer(pick_sample(), 1'($urandom_range(1, restart_odds) == 1));
        random_sent++;
      end
      phase++;
    end

    // drain, then give stray medians time to show up
    settle();
    if (fail_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
